// File: design/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

   typedef logic signed [31:0] deq_word_type;
   typedef logic [1:0]         deq_status_type;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_SIZE       = 3'd4,
      KIND_EMPTY      = 3'd5,
      KIND_PEEK_FRONT = 3'd6,
      KIND_PEEK_BACK  = 3'd7
   } deq_kind_type;

   localparam deq_status_type ST_OK    = 2'd0;
   localparam deq_status_type ST_EMPTY = 2'd1;
   localparam deq_status_type ST_FULL  = 2'd2;

   localparam deq_word_type MINUS_ONE = -32'sd1;

   // Result of one transaction as it leaves the pointer logic.
   typedef struct packed {
      logic           emit;
      logic           use_ram;
      deq_word_type   value;
      deq_status_type status;
   } deq_issue_type;

endpackage

// File: design/deq_req_if.sv
// Request channel: operation code and push word.
interface deq_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic signed [31:0] push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// File: design/deq_rsp_if.sv
// Response channel: result word and status.
interface deq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink   (input valid, input result_value, input status, output ready);
endinterface

// File: design/deq_ram.sv
// Single-port-write, single-port-read entry store with registered read data.
module deq_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  deq_pkg::deq_word_type wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output deq_pkg::deq_word_type rd_data
);
   import deq_pkg::*;

   deq_word_type mem [DEPTH];
   deq_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/deq_ctrl.sv
// Front/back pointers, occupancy and per-transaction memory access decode.
module deq_ctrl #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int CW    = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  deq_pkg::deq_kind_type  kind,
   input  deq_pkg::deq_word_type  push_value,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output deq_pkg::deq_word_type  wr_data,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   output deq_pkg::deq_issue_type issue
);
   import deq_pkg::*;

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] back_ff, back_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] front_prev, front_next, back_prev, back_next;
   logic          empty, full;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == FULL_COUNT);
   assign front_prev = (front_ff == '0) ? LAST : front_ff - AW'(1);
   assign front_next = (front_ff == LAST) ? '0 : front_ff + AW'(1);
   assign back_prev  = (back_ff == '0) ? LAST : back_ff - AW'(1);
   assign back_next  = (back_ff == LAST) ? '0 : back_ff + AW'(1);
   assign wr_data    = push_value;

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      issue.emit    = 1'b1;
      issue.use_ram = 1'b0;
      issue.value   = '0;
      issue.status  = ST_OK;
      unique case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (full) begin
               issue.status = ST_FULL;
            end else begin
               issue.emit = 1'b0;
               wr_en      = accept;
               count_in   = count_ff + CW'(1);
               if (kind == KIND_PUSH_FRONT) begin
                  wr_addr  = front_prev;
                  front_in = front_prev;
               end else begin
                  wr_addr = back_ff;
                  back_in = back_next;
               end
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
            if (empty) begin
               issue.value  = MINUS_ONE;
               issue.status = ST_EMPTY;
            end else begin
               issue.use_ram = 1'b1;
               rd_en         = accept;
               rd_addr       = (kind == KIND_POP_BACK || kind == KIND_PEEK_BACK)
                               ? back_prev : front_ff;
               if (kind == KIND_POP_FRONT) begin
                  front_in = front_next;
                  count_in = count_ff - CW'(1);
               end else if (kind == KIND_POP_BACK) begin
                  back_in  = back_prev;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         KIND_SIZE: begin
            issue.value = 32'(count_ff);
         end
         KIND_EMPTY: begin
            issue.value = {31'b0, empty};
         end
         default: begin
            issue.value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end
endmodule

// File: design/double_ended_queue_top.sv
// Double-ended queue top level: pointer control, entry store, response stages.
//
// Usage:
//   req_chan carries one operation per transaction (kind, push_value); rsp_chan
//   returns result_value and status. A transaction is taken when valid and
//   ready are both high. Successful pushes return nothing; every other
//   operation, and a push refused because the ring is full, returns one
//   response.
//   Path: an accepted request is registered in the pending stage, alongside the
//   synchronous read of the entry store, and then moves into the response
//   register.
//   Throughput: one transaction per cycle while rsp_chan drains freely; the
//   single read port of the entry store and the one-deep pending stage in
//   front of the response register set this.
//   Stall: when rsp_chan.ready is low the response register holds, the
//   pending stage fills, and req_chan.ready drops until space frees up.
//   Reset: synchronous, clears pointers, count and both stages; ready is low
//   during reset. Entry contents are not cleared and need no clearing pass.
module double_ended_queue_top #(
   parameter int DEPTH = 1024
) (
   input logic       clock,
   input logic       reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic          accept;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   deq_word_type  wr_data, rd_data;
   deq_issue_type issue;

   logic           pend_valid_ff, pend_valid_in;
   logic           pend_use_ram_ff;
   deq_word_type   pend_value_ff;
   deq_status_type pend_status_ff;
   logic           pend_move;

   logic           rsp_valid_ff, rsp_valid_in;
   deq_word_type   rsp_value_ff;
   deq_status_type rsp_status_ff;

   assign pend_move      = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!pend_valid_ff || pend_move);
   assign accept         = req_chan.valid && req_chan.ready;

   deq_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (deq_kind_type'(req_chan.kind)),
      .push_value (req_chan.push_value),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .issue      (issue)
   );

   deq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff && !pend_move;
      if (accept && issue.emit) begin
         pend_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && issue.emit) begin
         pend_use_ram_ff <= issue.use_ram;
         pend_value_ff   <= issue.value;
         pend_status_ff  <= issue.status;
      end
      if (pend_move) begin
         rsp_value_ff  <= pend_use_ram_ff ? rd_data : pend_value_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
endmodule

// File: design/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic [1:0]  rsp_status
);
   import deq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request two cycles earlier");

   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_result_value == 32'hFFFF_FFFF)
      else $error("empty status without -1");

   a_full_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_result_value == 32'h0)
      else $error("full status with nonzero value");

   a_flag_ok: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(req_valid && req_ready
         && req_kind == KIND_EMPTY, 2)
      |-> rsp_status == ST_OK && rsp_result_value[31:1] == '0)
      else $error("empty query gave a bad response");
endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_kind         (req_chan.kind),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_result_value (rsp_chan.result_value),
   .rsp_status       (rsp_chan.status)
);

// File: dv/double_ended_queue_top_tb.sv
// Testbench for double_ended_queue_top: directed and random deque operations.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 1024;
   localparam int RANDOM_OPS  = 209;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      deq_word_type   value;
      deq_status_type status;
   } deq_result_type;

   class deque_book;
      int             depth;
      int             failures;
      deq_word_type   words[$];
      deq_result_type awaited[$];

      function new(int depth_in);
         depth    = depth_in;
         failures = 0;
      endfunction

      function void add_result(deq_word_type v, deq_status_type s);
         deq_result_type r;
         r.value  = v;
         r.status = s;
         awaited.insert(awaited.size(), r);
      endfunction

      // Apply one accepted operation to the model and queue its response, if it has one.
      function void apply_op(deq_kind_type k, deq_word_type w);
         case (k)
            KIND_PUSH_FRONT: begin
               if (words.size() >= depth) add_result(0, ST_FULL);
               else words.insert(0, w);
            end
            KIND_PUSH_BACK: begin
               if (words.size() >= depth) add_result(0, ST_FULL);
               else words.insert(words.size(), w);
            end
            KIND_POP_FRONT: begin
               if (words.size() == 0) add_result(MINUS_ONE, ST_EMPTY);
               else begin
                  add_result(words[0], ST_OK);
                  words.delete(0);
               end
            end
            KIND_POP_BACK: begin
               if (words.size() == 0) add_result(MINUS_ONE, ST_EMPTY);
               else begin
                  add_result(words[words.size() - 1], ST_OK);
                  words.delete(words.size() - 1);
               end
            end
            KIND_SIZE: add_result(deq_word_type'(words.size()), ST_OK);
            KIND_EMPTY: add_result((words.size() == 0) ? 1 : 0, ST_OK);
            KIND_PEEK_FRONT: begin
               if (words.size() == 0) add_result(MINUS_ONE, ST_EMPTY);
               else add_result(words[0], ST_OK);
            end
            default: begin
               if (words.size() == 0) add_result(MINUS_ONE, ST_EMPTY);
               else add_result(words[words.size() - 1], ST_OK);
            end
         endcase
      endfunction

      function void match_result(deq_word_type v, deq_status_type s);
         deq_result_type e;
         if (awaited.size() == 0) begin
            $error("unexpected response: result_value %0d status %0d", v, s);
            failures++;
            return;
         end
         e = awaited[0];
         awaited.delete(0);
         if (v !== e.value) begin
            $error("result_value: expected %0d, actual %0d", e.value, v);
            failures++;
         end
         if (s !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, s);
            failures++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   deq_req_if req_chan ();
   deq_rsp_if rsp_chan ();

   double_ended_queue_top #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deque_book book = new(QUEUE_DEPTH);

   int  cycle_count;
   int  rsp_seen;
   int  hold_left;
   int  stall_left;
   bit  pressure_done;

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.kind       = 3'd0;
      req_chan.push_value = 32'sd0;
      rsp_chan.ready      = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 24);
   endfunction

   function automatic deq_word_type pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return deq_word_type'($urandom);
      endcase
   endfunction

   task automatic send_op(input deq_kind_type k, input deq_word_type w, input bit quiet);
      int gap;
      gap = quiet ? 0 : idle_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= k;
      req_chan.push_value <= w;
      do @(posedge clock); while (!req_chan.ready);
      book.apply_op(k, w);
   endtask

   task automatic run_random(input int count);
      int           n;
      int           push_pct;
      int           r;
      bit           quiet;
      deq_kind_type k;
      push_pct = 50;
      quiet    = 1'b0;
      for (n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 50;
               default: push_pct = 15;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 99) < push_pct) begin
            k = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
         end else begin
            r = $urandom_range(0, 9);
            if (r < 3)       k = KIND_POP_FRONT;
            else if (r < 6)  k = KIND_POP_BACK;
            else if (r == 6) k = KIND_SIZE;
            else if (r == 7) k = KIND_EMPTY;
            else if (r == 8) k = KIND_PEEK_FRONT;
            else             k = KIND_PEEK_BACK;
         end
         send_op(k, pick_word(), quiet);
      end
   endtask

   // Response side: random stalls, quiet stretches, and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            book.match_result(rsp_chan.result_value, rsp_chan.status);
            rsp_seen++;
         end
         if (!pressure_done && rsp_seen >= 40) begin
            pressure_done = 1'b1;
            hold_left     = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = ((rsp_seen / 100) % 3 == 1) ? 0 : idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("double_ended_queue_top_tb failed");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty queue: pops and peeks answer -1; then size, empty, two pushes, and peeks and pops on them
      send_op(KIND_POP_FRONT, 32'sd0, 1'b0);
      send_op(KIND_POP_BACK, 32'sd0, 1'b0);
      send_op(KIND_PEEK_FRONT, 32'sd0, 1'b0);
      send_op(KIND_PEEK_BACK, 32'sd0, 1'b0);
      send_op(KIND_SIZE, 32'sd0, 1'b0);
      send_op(KIND_EMPTY, 32'sd0, 1'b0);
      send_op(KIND_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b0);
      send_op(KIND_PUSH_BACK, 32'sh8000_0000, 1'b0);
      send_op(KIND_PEEK_FRONT, 32'sd0, 1'b1);
      send_op(KIND_PEEK_BACK, 32'sd0, 1'b1);
      send_op(KIND_SIZE, 32'sd0, 1'b1);
      send_op(KIND_EMPTY, 32'sd0, 1'b1);
      send_op(KIND_POP_FRONT, 32'sd0, 1'b1);
      send_op(KIND_POP_BACK, 32'sd0, 1'b1);
      // fill to full across the pointer wrap, then refused pushes
      for (n = 0; n < QUEUE_DEPTH; n++) begin
         if (n % 2 == 0) begin
            send_op(KIND_PUSH_BACK, pick_word(), (n % 8 != 0));
         end else begin
            send_op(KIND_PUSH_FRONT, pick_word(), (n % 8 != 1));
         end
      end
      send_op(KIND_PUSH_FRONT, 32'sh1234_5678, 1'b0);
      send_op(KIND_PUSH_BACK, 32'sh1234_5678, 1'b0);
      send_op(KIND_SIZE, 32'sd0, 1'b0);

      run_random(RANDOM_OPS);
      req_chan.valid <= 1'b0;

      while (book.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.failures == 0) begin
         $display("double_ended_queue_top_tb passed");
      end else begin
         $display("double_ended_queue_top_tb failed");
      end
      $finish;
   end

endmodule
